### sv/assert_macros.svh
// Assertion macros for the RTL files; etq_combine includes them.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_RST(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");
`define ASSERT_CLK(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("%m: check failed");
`else
`define ASSERT_RST(lbl, clk, rst, prop)
`define ASSERT_CLK(lbl, clk, prop)
`endif
`endif

### sv/etq_pkg.sv
// Shared widths, constants, lane types and the arctangent table for the
// Euler-to-quaternion pipeline. No dependencies.
package etq_pkg;

   localparam int LANES             = 3;
   localparam int LANE_ROLL         = 0;
   localparam int LANE_PITCH        = 1;
   localparam int LANE_YAW          = 2;

   localparam int ANGLE_W           = 16;   // Q3.13 input angle
   localparam int Q_W               = 16;   // Q1.14 result
   localparam int Z_W               = 34;   // CORDIC angle accumulator, Q.30
   localparam int XY_W              = 33;   // CORDIC vector, Q.30
   localparam int TRIG_W            = 17;   // rounded sine/cosine, Q.15
   localparam int PAIR_W            = 34;   // product of two Q.15 values
   localparam int TRIPLE_W          = 48;   // product of three Q.15 values
   localparam int SUM_W             = TRIPLE_W + 1;

   localparam int CORDIC_STAGES_DEF = 14;
   localparam int ATAN_ENTRIES      = 24;
   localparam int ONE_Q14           = 16384;

   localparam logic signed [XY_W-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;
   localparam logic signed [Z_W-1:0]  HALF_PI_Q30     = 34'sd1686629713;
   localparam logic signed [Z_W-1:0]  PI_Q30          = 34'sd3373259426;

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
      logic                   flip;
   } cordic_lane_type;

   typedef cordic_lane_type [LANES-1:0] cordic_vec_type;

   // atan(2^-i) in Q.30
   function automatic logic signed [Z_W-1:0] atan_q30(input int unsigned idx);
      logic signed [Z_W-1:0] a;
      case (idx)
         0:       a = 34'sd843314857;
         1:       a = 34'sd497837830;
         2:       a = 34'sd263043837;
         3:       a = 34'sd133525159;
         4:       a = 34'sd67021687;
         5:       a = 34'sd33543516;
         6:       a = 34'sd16775851;
         7:       a = 34'sd8388437;
         8:       a = 34'sd4194283;
         9:       a = 34'sd2097149;
         10:      a = 34'sd1048576;
         11:      a = 34'sd524288;
         12:      a = 34'sd262144;
         13:      a = 34'sd131072;
         14:      a = 34'sd65536;
         15:      a = 34'sd32768;
         16:      a = 34'sd16384;
         17:      a = 34'sd8192;
         18:      a = 34'sd4096;
         19:      a = 34'sd2048;
         20:      a = 34'sd1024;
         21:      a = 34'sd512;
         22:      a = 34'sd256;
         23:      a = 34'sd128;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

### sv/etq_cordic_stage.sv
// One registered rotation-mode CORDIC iteration for the roll, pitch and yaw
// lanes, with its own valid/ready stage. Depends on etq_pkg.
module etq_cordic_stage
   import etq_pkg::*;
#(
   parameter int STAGE = 0
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  cordic_vec_type in_lanes,
   output logic           out_valid,
   input  logic           out_ready,
   output cordic_vec_type out_lanes
);

   localparam logic signed [Z_W-1:0] ATAN_STEP = atan_q30(STAGE);

   cordic_vec_type lanes_in;
   cordic_vec_type lanes_ff;
   logic           valid_ff;

   always_comb begin
      logic signed [XY_W-1:0] xv;
      logic signed [XY_W-1:0] yv;
      logic signed [Z_W-1:0]  zv;
      logic signed [XY_W-1:0] dx;
      logic signed [XY_W-1:0] dy;
      for (int l = 0; l < LANES; l++) begin
         xv = in_lanes[l].x;
         yv = in_lanes[l].y;
         zv = in_lanes[l].z;
         dx = yv >>> STAGE;
         dy = xv >>> STAGE;
         lanes_in[l].flip = in_lanes[l].flip;
         if (!zv[Z_W-1]) begin
            lanes_in[l].x = xv - dx;
            lanes_in[l].y = yv + dy;
            lanes_in[l].z = zv - ATAN_STEP;
         end else begin
            lanes_in[l].x = xv + dx;
            lanes_in[l].y = yv - dy;
            lanes_in[l].z = zv + ATAN_STEP;
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         lanes_ff <= lanes_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_lanes = lanes_ff;

endmodule

### sv/etq_combine.sv
// Rounds the CORDIC sines and cosines, forms the quaternion products and
// sums, then rounds and saturates to Q1.14. Four registered stages.
// Depends on etq_pkg and assert_macros.svh.
`include "assert_macros.svh"
module etq_combine
   import etq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  cordic_vec_type        in_lanes,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic signed [Q_W-1:0] quat_w,
   output logic signed [Q_W-1:0] quat_x,
   output logic signed [Q_W-1:0] quat_y,
   output logic signed [Q_W-1:0] quat_z
);

   localparam logic signed [SUM_W-1:0]  RND_Q45 = SUM_W'(2**30);
   localparam logic signed [SUM_W-1:0]  ONE_S   = SUM_W'(ONE_Q14);
   localparam logic signed [XY_W-1:0]   RND_Q30 = XY_W'(2**14);

   function automatic logic signed [TRIG_W-1:0] round_q15(
      input logic signed [XY_W-1:0] v,
      input logic                   flip
   );
      logic signed [XY_W-1:0] r;
      r = (flip ? -v : v) + RND_Q30;
      return TRIG_W'(r >>> 15);
   endfunction

   function automatic logic signed [Q_W-1:0] sat_q14(input logic signed [SUM_W-1:0] s);
      logic signed [SUM_W-1:0] q;
      logic signed [Q_W-1:0]   res;
      q = (s + RND_Q45) >>> 31;
      if (q > ONE_S) begin
         res = Q_W'(ONE_Q14);
      end else if (q < -ONE_S) begin
         res = -Q_W'(ONE_Q14);
      end else begin
         res = Q_W'(q);
      end
      return res;
   endfunction

   // stage A: rounded trig values
   logic                     a_valid_ff;
   logic signed [TRIG_W-1:0] cos_ff [LANES];
   logic signed [TRIG_W-1:0] sin_ff [LANES];
   // stage B: pitch/yaw pair products
   logic                     b_valid_ff;
   logic signed [TRIG_W-1:0] cr_ff, sr_ff;
   logic signed [PAIR_W-1:0] cpcy_ff, spsy_ff, cpsy_ff, spcy_ff;
   // stage C: triple products
   logic                       c_valid_ff;
   logic signed [TRIPLE_W-1:0] w1_ff, w2_ff, x1_ff, x2_ff, y1_ff, y2_ff, z1_ff, z2_ff;
   // stage D: output register
   logic                  d_valid_ff;
   logic signed [Q_W-1:0] qw_ff, qx_ff, qy_ff, qz_ff;

   logic a_ready, b_ready, c_ready, d_ready;

   assign d_ready  = !d_valid_ff || out_ready;
   assign c_ready  = !c_valid_ff || d_ready;
   assign b_ready  = !b_valid_ff || c_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         if (a_ready) a_valid_ff <= in_valid;
         if (b_ready) b_valid_ff <= a_valid_ff;
         if (c_ready) c_valid_ff <= b_valid_ff;
         if (d_ready) d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && a_ready) begin
         for (int l = 0; l < LANES; l++) begin
            cos_ff[l] <= round_q15(in_lanes[l].x, in_lanes[l].flip);
            sin_ff[l] <= round_q15(in_lanes[l].y, in_lanes[l].flip);
         end
      end
      if (a_valid_ff && b_ready) begin
         cr_ff   <= cos_ff[LANE_ROLL];
         sr_ff   <= sin_ff[LANE_ROLL];
         cpcy_ff <= cos_ff[LANE_PITCH] * cos_ff[LANE_YAW];
         spsy_ff <= sin_ff[LANE_PITCH] * sin_ff[LANE_YAW];
         cpsy_ff <= cos_ff[LANE_PITCH] * sin_ff[LANE_YAW];
         spcy_ff <= sin_ff[LANE_PITCH] * cos_ff[LANE_YAW];
      end
      if (b_valid_ff && c_ready) begin
         w1_ff <= cr_ff * cpcy_ff;
         w2_ff <= sr_ff * spsy_ff;
         x1_ff <= sr_ff * cpcy_ff;
         x2_ff <= cr_ff * spsy_ff;
         y1_ff <= cr_ff * spcy_ff;
         y2_ff <= sr_ff * cpsy_ff;
         z1_ff <= cr_ff * cpsy_ff;
         z2_ff <= sr_ff * spcy_ff;
      end
      if (c_valid_ff && d_ready) begin
         qw_ff <= sat_q14(SUM_W'(w1_ff) + SUM_W'(w2_ff));
         qx_ff <= sat_q14(SUM_W'(x1_ff) - SUM_W'(x2_ff));
         qy_ff <= sat_q14(SUM_W'(y1_ff) + SUM_W'(y2_ff));
         qz_ff <= sat_q14(SUM_W'(z1_ff) - SUM_W'(z2_ff));
      end
   end

   assign out_valid = d_valid_ff;
   assign quat_w    = qw_ff;
   assign quat_x    = qx_ff;
   assign quat_y    = qy_ff;
   assign quat_z    = qz_ff;

   // back-pressure reaches the input only once every stage here holds a beat
   `ASSERT_RST(full_when_blocked, clock, reset, !in_ready |-> a_valid_ff && b_valid_ff && c_valid_ff && d_valid_ff)
   `ASSERT_RST(w_in_range, clock, reset, d_valid_ff |-> qw_ff <= 16'sd16384 && qw_ff >= -16'sd16384)
   `ASSERT_CLK(empty_after_reset, clock, reset |=> !out_valid)

endmodule

### sv/euler_to_quaternion.sv
// Euler angles to rotation quaternion.
// Input beat: roll, pitch and yaw in radians, signed Q3.13, any code accepted
// (half angles outside +-pi/2 are folded by pi and the result negated).
// Output beat: quaternion w, x, y, z, signed Q1.14, saturated to +-1.0.
// Both channels are valid/ready; a beat moves when valid and ready are high.
// From input beat to output valid, each beat passes through one fold stage,
// one register per CORDIC iteration, then the round, pair product, triple
// product and output stages of etq_combine.
// Throughput: one beat per cycle while rsp_ready is high; every stage holds its own valid bit.
// When the receiver stalls, beats pile up behind the output register and
// empty stages keep filling, so req_ready drops only once the whole
// pipeline is full. Nothing is lost or repeated across a stall.
// Reset (synchronous, active high) clears all valid bits; no state is kept.
// Depends on etq_pkg, etq_cordic_stage and etq_combine.
module euler_to_quaternion
   import etq_pkg::*;
#(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [ANGLE_W-1:0] req_roll_angle,
   input  logic signed [ANGLE_W-1:0] req_pitch_angle,
   input  logic signed [ANGLE_W-1:0] req_yaw_angle,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [Q_W-1:0]     rsp_quat_w,
   output logic signed [Q_W-1:0]     rsp_quat_x,
   output logic signed [Q_W-1:0]     rsp_quat_y,
   output logic signed [Q_W-1:0]     rsp_quat_z
);

   logic signed [ANGLE_W-1:0] angle [LANES];
   cordic_vec_type            fold_in;
   cordic_vec_type            fold_ff;
   logic                      fold_valid_ff;

   cordic_vec_type chain_lanes [CORDIC_STAGES+1];
   logic           chain_valid [CORDIC_STAGES+1];
   logic           chain_ready [CORDIC_STAGES+1];

   assign angle[LANE_ROLL]  = req_roll_angle;
   assign angle[LANE_PITCH] = req_pitch_angle;
   assign angle[LANE_YAW]   = req_yaw_angle;

   // half angle in Q.30 is the Q3.13 code shifted up by 16
   always_comb begin
      logic signed [Z_W-1:0] z0;
      for (int l = 0; l < LANES; l++) begin
         z0 = Z_W'(angle[l]) <<< 16;
         fold_in[l].x = CORDIC_GAIN_Q30;
         fold_in[l].y = '0;
         if (z0 > HALF_PI_Q30) begin
            fold_in[l].z    = z0 - PI_Q30;
            fold_in[l].flip = 1'b1;
         end else if (z0 < -HALF_PI_Q30) begin
            fold_in[l].z    = z0 + PI_Q30;
            fold_in[l].flip = 1'b1;
         end else begin
            fold_in[l].z    = z0;
            fold_in[l].flip = 1'b0;
         end
      end
   end

   assign req_ready = !fold_valid_ff || chain_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_valid_ff <= 1'b0;
      end else if (req_ready) begin
         fold_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         fold_ff <= fold_in;
      end
   end

   assign chain_lanes[0] = fold_ff;
   assign chain_valid[0] = fold_valid_ff;

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      etq_cordic_stage #(
         .STAGE (i)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_ready  (chain_ready[i]),
         .in_lanes  (chain_lanes[i]),
         .out_valid (chain_valid[i+1]),
         .out_ready (chain_ready[i+1]),
         .out_lanes (chain_lanes[i+1])
      );
   end

   etq_combine u_combine (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chain_valid[CORDIC_STAGES]),
      .in_ready  (chain_ready[CORDIC_STAGES]),
      .in_lanes  (chain_lanes[CORDIC_STAGES]),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .quat_w    (rsp_quat_w),
      .quat_x    (rsp_quat_x),
      .quat_y    (rsp_quat_y),
      .quat_z    (rsp_quat_z)
   );

endmodule
